/* src/json_token_scanner_macros.svh */
// Assertion macros shared by the JSON token scanner modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef JSON_TOKEN_SCANNER_MACROS_SVH
`define JSON_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define JTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json_token_scanner: assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define JTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json_token_scanner: assertion failed");
`else
`define JTS_ASSERT_IMP(label, ante, cons)
`define JTS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/jts_pkg.sv */
// Shared types and constants of the JSON token scanner.
`timescale 1ns / 1ps
package jts_pkg;

  // Width of the internal byte position counters; outputs carry the low 32 bits.
  localparam int OFFSET_BITS = 32;

  // Up to this many tokens can result from one input byte.
  localparam int MAX_RES  = 3;
  localparam int CNT_BITS = $clog2(MAX_RES + 1);
  localparam int IDX_BITS = $clog2(MAX_RES);

  typedef logic [OFFSET_BITS-1:0] jts_pos_t;

  // Token kind codes as seen on the result channel.
  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_STRING   = 4'd4,
    KIND_NUMBER   = 4'd5,
    KIND_BOOL     = 4'd6,
    KIND_NULL     = 4'd7,
    KIND_COLON    = 4'd8,
    KIND_COMMA    = 4'd9,
    KIND_ERROR    = 4'd10,
    KIND_END      = 4'd11
  } jts_kind_t;

  // One result token.
  typedef struct packed {
    jts_kind_t   kind;
    logic [31:0] offset;
    logic [31:0] length;
  } jts_token_t;

  // All tokens caused by one input byte, in emission order.
  typedef struct packed {
    logic [CNT_BITS-1:0]          count;
    jts_token_t [MAX_RES-1:0]     tok;
  } jts_bundle_t;

endpackage

/* src/jts_in_if.sv */
// Input byte channel of the JSON token scanner.
`timescale 1ns / 1ps
interface jts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

/* src/jts_out_if.sv */
// Result token channel of the JSON token scanner.
`timescale 1ns / 1ps
interface jts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_offset;
  logic [31:0] token_length;
  logic        run_last;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input run_last, output ready);
endinterface

/* src/jts_scan_core.sv */
// Scanner state and the per-byte token decision logic.
`timescale 1ns / 1ps
`include "json_token_scanner_macros.svh"
module jts_scan_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output jts_pkg::jts_bundle_t bundle
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_MINUS,
    MODE_NUM,
    MODE_LIT
  } mode_t;

  // Literal selectors.
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // Byte codes of interest.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOW_E    = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_LOW_T    = 8'h74;
  localparam logic [7:0] CH_LOW_F    = 8'h66;
  localparam logic [7:0] CH_LOW_N    = 8'h6E;
  localparam logic [7:0] CH_LOW_R    = 8'h72;
  localparam logic [7:0] CH_LOW_U    = 8'h75;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_L    = 8'h6C;
  localparam logic [7:0] CH_LOW_S    = 8'h73;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam int NSLOT = 4;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_num_byte(logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_UP_E) ||
           (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] k);
    logic [2:0] n;
    case (k)
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  // Expected byte of a literal at a given index.
  function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      LIT_FALSE: begin
        case (idx)
          3'd0:    ch = CH_LOW_F;
          3'd1:    ch = CH_LOW_A;
          3'd2:    ch = CH_LOW_L;
          3'd3:    ch = CH_LOW_S;
          3'd4:    ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    ch = CH_LOW_N;
          3'd1:    ch = CH_LOW_U;
          3'd2:    ch = CH_LOW_L;
          3'd3:    ch = CH_LOW_L;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    ch = CH_LOW_T;
          3'd1:    ch = CH_LOW_R;
          3'd2:    ch = CH_LOW_U;
          3'd3:    ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [31:0] low32(jts_pkg::jts_pos_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic jts_pkg::jts_token_t mk_tok(jts_pkg::jts_kind_t kind,
                                                 jts_pkg::jts_pos_t off,
                                                 jts_pkg::jts_pos_t len);
    jts_pkg::jts_token_t t;
    t.kind   = kind;
    t.offset = low32(off);
    t.length = low32(len);
    return t;
  endfunction

  mode_t              mode_r, mode_nxt;
  logic [2:0]         lidx_r, lidx_nxt;
  logic [1:0]         lkind_r, lkind_nxt;
  jts_pkg::jts_pos_t  begin_r, begin_nxt;
  jts_pkg::jts_pos_t  pos_r, pos_nxt;
  logic               err_r, err_nxt;

  jts_pkg::jts_pos_t  pos_next;
  logic               do_start;
  logic [1:0]         k_sel;
  logic [2:0]         lidx_inc;
  logic               slot_v [NSLOT];
  jts_pkg::jts_token_t slot_tok [NSLOT];
  logic [jts_pkg::CNT_BITS-1:0] cnt;

  assign pos_next = pos_r + jts_pkg::jts_pos_t'(1);
  assign k_sel    = (lkind_r > LIT_NULL) ? LIT_TRUE : lkind_r;
  assign lidx_inc = lidx_r + 3'd1;

  // Token decision for one byte: the current mode, a new token start,
  // then the closing work of the last byte.
  always_comb begin
    mode_nxt  = mode_r;
    lidx_nxt  = lidx_r;
    lkind_nxt = lkind_r;
    begin_nxt = begin_r;
    err_nxt   = err_r;
    pos_nxt   = pos_next;
    do_start  = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_v[i]   = 1'b0;
      slot_tok[i] = '0;
    end

    if (!err_r) begin
      case (mode_r)
        MODE_STR: begin
          if (data_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (data_byte == CH_QUOTE) begin
            slot_v[0]   = 1'b1;
            slot_tok[0] = mk_tok(jts_pkg::KIND_STRING, begin_r, pos_r - begin_r);
            mode_nxt    = MODE_IDLE;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_STR;
        end
        MODE_MINUS: begin
          if (is_digit(data_byte)) begin
            mode_nxt = MODE_NUM;
          end else begin
            slot_v[0]   = 1'b1;
            slot_tok[0] = mk_tok(jts_pkg::KIND_ERROR, begin_r, '0);
            err_nxt     = 1'b1;
            mode_nxt    = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (!is_num_byte(data_byte)) begin
            slot_v[0]   = 1'b1;
            slot_tok[0] = mk_tok(jts_pkg::KIND_NUMBER, begin_r, pos_r - begin_r);
            mode_nxt    = MODE_IDLE;
            do_start    = 1'b1;
          end
        end
        MODE_LIT: begin
          if ((lidx_r < lit_len(k_sel)) && (data_byte == lit_char(k_sel, lidx_r))) begin
            lidx_nxt = lidx_inc;
            if (lidx_inc == lit_len(k_sel)) begin
              slot_v[0]   = 1'b1;
              slot_tok[0] = mk_tok((k_sel == LIT_NULL) ? jts_pkg::KIND_NULL
                                                       : jts_pkg::KIND_BOOL,
                                   begin_r, jts_pkg::jts_pos_t'(lit_len(k_sel)));
              mode_nxt    = MODE_IDLE;
              lidx_nxt    = 3'd0;
            end
          end else begin
            slot_v[0]   = 1'b1;
            slot_tok[0] = mk_tok(jts_pkg::KIND_ERROR, begin_r, '0);
            err_nxt     = 1'b1;
            mode_nxt    = MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_start = 1'b1;
        end
      endcase
    end

    // Start of a new token at the current byte.
    if (do_start) begin
      case (data_byte)
        CH_LBRACE: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_LBRACE, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_RBRACE: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_RBRACE, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_LBRACKET: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_LBRACKET, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_RBRACKET: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_RBRACKET, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_COLON: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_COLON, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_COMMA: begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = mk_tok(jts_pkg::KIND_COMMA, pos_r, jts_pkg::jts_pos_t'(1));
        end
        CH_QUOTE: begin
          mode_nxt  = MODE_STR;
          begin_nxt = pos_next;
        end
        CH_LOW_T: begin
          mode_nxt  = MODE_LIT;
          lkind_nxt = LIT_TRUE;
          lidx_nxt  = 3'd1;
          begin_nxt = pos_r;
        end
        CH_LOW_F: begin
          mode_nxt  = MODE_LIT;
          lkind_nxt = LIT_FALSE;
          lidx_nxt  = 3'd1;
          begin_nxt = pos_r;
        end
        CH_LOW_N: begin
          mode_nxt  = MODE_LIT;
          lkind_nxt = LIT_NULL;
          lidx_nxt  = 3'd1;
          begin_nxt = pos_r;
        end
        CH_MINUS: begin
          mode_nxt  = MODE_MINUS;
          begin_nxt = pos_r;
        end
        default: begin
          if (is_digit(data_byte)) begin
            mode_nxt  = MODE_NUM;
            begin_nxt = pos_r;
          end else if (!is_space(data_byte)) begin
            slot_v[1]   = 1'b1;
            slot_tok[1] = mk_tok(jts_pkg::KIND_ERROR, pos_r, '0);
            err_nxt     = 1'b1;
            mode_nxt    = MODE_IDLE;
          end
        end
      endcase
    end

    // The last byte closes any pending token, adds the end token and
    // returns the scanner to its reset state.
    if (final_byte) begin
      if (!err_nxt) begin
        if (mode_nxt == MODE_NUM) begin
          slot_v[2]   = 1'b1;
          slot_tok[2] = mk_tok(jts_pkg::KIND_NUMBER, begin_nxt, pos_next - begin_nxt);
        end else if (mode_nxt != MODE_IDLE) begin
          slot_v[2]   = 1'b1;
          slot_tok[2] = mk_tok(jts_pkg::KIND_ERROR, begin_nxt, '0);
        end
      end
      slot_v[3]   = 1'b1;
      slot_tok[3] = mk_tok(jts_pkg::KIND_END, pos_next, '0);
      mode_nxt  = MODE_IDLE;
      lidx_nxt  = 3'd0;
      lkind_nxt = LIT_TRUE;
      begin_nxt = '0;
      err_nxt   = 1'b0;
      pos_nxt   = '0;
    end
  end

  // Pack the valid slots in order, keeping at most MAX_RES of them.
  always_comb begin
    cnt        = '0;
    bundle.tok = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_v[i] && (cnt < jts_pkg::CNT_BITS'(jts_pkg::MAX_RES))) begin
        bundle.tok[cnt[jts_pkg::IDX_BITS-1:0]] = slot_tok[i];
        cnt = cnt + jts_pkg::CNT_BITS'(1);
      end
    end
    bundle.count = cnt;
  end

  // Scanner state advances once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      lidx_r  <= 3'd0;
      lkind_r <= LIT_TRUE;
      begin_r <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      lidx_r  <= lidx_nxt;
      lkind_r <= lkind_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

  `JTS_ASSERT_NXT(a_final_clears, in_fire && final_byte, (pos_r == '0) && (mode_r == MODE_IDLE) && !err_r)
  `JTS_ASSERT_IMP(a_err_idle, err_r, mode_r == MODE_IDLE)
  `JTS_ASSERT_NXT(a_pos_step, in_fire && !final_byte, pos_r == ($past(pos_r) + jts_pkg::jts_pos_t'(1)))

endmodule

/* src/jts_result_buf.sv */
// Result register that holds the tokens of one byte and hands them out one by one.
`timescale 1ns / 1ps
`include "json_token_scanner_macros.svh"
module jts_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jts_pkg::jts_bundle_t bundle,
  output logic                 in_ready,
  jts_out_if.source            out_ch
);

  jts_pkg::jts_token_t [jts_pkg::MAX_RES-1:0] res_r;
  logic [jts_pkg::CNT_BITS-1:0] rem_r, rem_nxt;
  logic [jts_pkg::IDX_BITS-1:0] idx_r, idx_nxt;
  logic                         pop;
  logic                         fill;
  jts_pkg::jts_token_t          head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign fill = load && (bundle.count != '0);

  // A new byte is taken when the buffer is empty or its last token leaves now.
  assign in_ready = (rem_r == '0) ||
                    ((rem_r == jts_pkg::CNT_BITS'(1)) && out_ch.ready);

  // Output side.
  assign head                = res_r[idx_r];
  assign out_ch.valid        = (rem_r != '0);
  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_offset = head.offset;
  assign out_ch.token_length = head.length;
  assign out_ch.run_last     = (rem_r == jts_pkg::CNT_BITS'(1));

  // Read pointer and remaining count.
  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (pop) begin
      rem_nxt = rem_r - jts_pkg::CNT_BITS'(1);
      if (rem_r == jts_pkg::CNT_BITS'(1)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + jts_pkg::IDX_BITS'(1);
      end
    end
    if (fill) begin
      rem_nxt = bundle.count;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Token storage needs no reset.
  always_ff @(posedge clk) begin
    if (fill) begin
      res_r <= bundle.tok;
    end
  end

  `JTS_ASSERT_NXT(a_fill_count, fill, rem_r == $past(bundle.count))
  `JTS_ASSERT_NXT(a_pop_advance, pop && !load && (rem_r > jts_pkg::CNT_BITS'(1)), idx_r == ($past(idx_r) + jts_pkg::IDX_BITS'(1)))
  `JTS_ASSERT_IMP(a_ptr_bound, 1'b1, ({1'b0, idx_r} + {1'b0, rem_r}) <= 3'(jts_pkg::MAX_RES))

endmodule

/* src/json_token_scanner.sv */
// Top level of the byte-serial JSON token scanner.
//
// Usage: JSON text enters one byte per request on in_ch (data_byte, with
// final_byte set on the last byte of a text). Tokens leave on out_ch, one per
// request, with kind, byte offset and length; run_last marks the last token
// caused by a byte. A byte can give zero to three tokens.
// Latency: the tokens of a byte are presented the cycle after the byte is
// accepted. Throughput: one byte per cycle as long as each byte gives at
// most one token and out_ch is ready; a byte that gives more tokens holds
// in_ch off until the last has left the single result register, whose read
// port passes one token per cycle while out_ch is ready.
// When out_ch stalls, the tokens of one byte wait in the result register and
// in_ch.ready drops until the last of them leaves; ready stays high while
// that last token is taken in the same cycle.
// Reset (rst_n low, synchronous) empties the result register and returns the
// scanner to offset 0 with no pending token. After the last byte of a text
// the scanner also returns to that state, so the next byte starts a new text.
`timescale 1ns / 1ps
module json_token_scanner (
  input  logic      clk,
  input  logic      rst_n,
  jts_in_if.sink    in_ch,
  jts_out_if.source out_ch
);

  logic                 buf_ready;
  logic                 in_fire;
  jts_pkg::jts_bundle_t bundle;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  // Per-byte token logic and scanner state.
  jts_scan_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .bundle     (bundle)
  );

  // Result register feeding the output channel.
  jts_result_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .bundle   (bundle),
    .in_ready (buf_ready),
    .out_ch   (out_ch)
  );

endmodule

/* sim/json_token_scanner_test.sv */
// Self-checking testbench for the byte-serial JSON token scanner.
`timescale 1ns / 1ps
module json_token_scanner_test;

  // Scanner modes of the token predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_STRING, SCAN_ESCAPE, SCAN_MINUS, SCAN_NUMBER, SCAN_LITERAL
  } scan_mode_t;

  // Literal selectors.
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    jts_pkg::jts_kind_t kind;
    logic [31:0]        offset;
    logic [31:0]        length;
    logic               run_last;
  } scan_token_t;

  logic clk;
  logic rst_n;

  jts_in_if  in_ch ();
  jts_out_if out_ch ();

  json_token_scanner i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be offered, and tokens the scanner still owes us.
  text_byte_t  bytes_pending[$];
  scan_token_t tokens_due[$];
  scan_token_t byte_tokens[$];
  logic [7:0]  text_buf[$];
  text_byte_t  next_item;
  scan_token_t want;

  // Predictor state.
  scan_mode_t        mode_q;
  logic [2:0]        lit_idx_q;
  logic [1:0]        lit_sel_q;
  jts_pkg::jts_pos_t tok_start_q;
  jts_pkg::jts_pos_t pos_q;
  logic              err_q;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_left   = 0;
  int errors         = 0;
  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int texts_closed   = 0;
  int tokens_checked = 0;
  int kind_hits[16];
  int kinds_seen;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    mode_q      = SCAN_IDLE;
    lit_idx_q   = 3'd0;
    lit_sel_q   = LIT_TRUE;
    tok_start_q = '0;
    pos_q       = '0;
    err_q       = 1'b0;
  endfunction

  function automatic logic [2:0] lit_size(logic [1:0] sel);
    return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] sel, logic [2:0] idx);
    case (sel)
      LIT_TRUE:  return (idx == 0) ? "t" : (idx == 1) ? "r" : (idx == 2) ? "u" : "e";
      LIT_FALSE: return (idx == 0) ? "f" : (idx == 1) ? "a" : (idx == 2) ? "l" :
                        (idx == 3) ? "s" : "e";
      default:   return (idx == 0) ? "n" : (idx == 1) ? "u" : "l";
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_num_byte(logic [7:0] c);
    return is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-";
  endfunction

  // The scanner emits at most MAX_RES tokens per byte; any more are dropped.
  function automatic void note_token(jts_pkg::jts_kind_t kind, jts_pkg::jts_pos_t offset,
                                     jts_pkg::jts_pos_t length);
    scan_token_t t;
    if (byte_tokens.size() < jts_pkg::MAX_RES) begin
      t.kind     = kind;
      t.offset   = offset[31:0];
      t.length   = length[31:0];
      t.run_last = 1'b0;
      byte_tokens.push_back(t);
    end
  endfunction

  function automatic void fail_at(jts_pkg::jts_pos_t offset);
    note_token(jts_pkg::KIND_ERROR, offset, '0);
    err_q  = 1'b1;
    mode_q = SCAN_IDLE;
  endfunction

  // Scan a byte that arrives between tokens.
  function automatic void open_token(logic [7:0] c, jts_pkg::jts_pos_t pos);
    case (c)
      "{": note_token(jts_pkg::KIND_LBRACE, pos, jts_pkg::jts_pos_t'(1));
      "}": note_token(jts_pkg::KIND_RBRACE, pos, jts_pkg::jts_pos_t'(1));
      "[": note_token(jts_pkg::KIND_LBRACKET, pos, jts_pkg::jts_pos_t'(1));
      "]": note_token(jts_pkg::KIND_RBRACKET, pos, jts_pkg::jts_pos_t'(1));
      ":": note_token(jts_pkg::KIND_COLON, pos, jts_pkg::jts_pos_t'(1));
      ",": note_token(jts_pkg::KIND_COMMA, pos, jts_pkg::jts_pos_t'(1));
      "\"": begin
        mode_q      = SCAN_STRING;
        tok_start_q = pos + 1'b1;
      end
      "t", "f", "n": begin
        mode_q      = SCAN_LITERAL;
        lit_sel_q   = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
        lit_idx_q   = 3'd1;
        tok_start_q = pos;
      end
      "-": begin
        mode_q      = SCAN_MINUS;
        tok_start_q = pos;
      end
      default: begin
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
          // Whitespace between tokens is skipped.
        end else if (is_digit(c)) begin
          mode_q      = SCAN_NUMBER;
          tok_start_q = pos;
        end else begin
          fail_at(pos);
        end
      end
    endcase
  endfunction

  // Work out the tokens caused by one accepted byte and queue them.
  function automatic void predict_tokens(logic [7:0] c, logic last);
    jts_pkg::jts_pos_t pos;
    jts_pkg::jts_pos_t nxt;
    pos = pos_q;
    nxt = pos_q + 1'b1;
    byte_tokens = {};
    if (!err_q) begin
      case (mode_q)
        SCAN_STRING: begin
          if (c == "\\") begin
            mode_q = SCAN_ESCAPE;
          end else if (c == "\"") begin
            note_token(jts_pkg::KIND_STRING, tok_start_q, pos - tok_start_q);
            mode_q = SCAN_IDLE;
          end
        end
        SCAN_ESCAPE: mode_q = SCAN_STRING;
        SCAN_MINUS: begin
          if (is_digit(c)) mode_q = SCAN_NUMBER;
          else fail_at(tok_start_q);
        end
        SCAN_NUMBER: begin
          if (!is_num_byte(c)) begin
            note_token(jts_pkg::KIND_NUMBER, tok_start_q, pos - tok_start_q);
            mode_q = SCAN_IDLE;
            open_token(c, pos);
          end
        end
        SCAN_LITERAL: begin
          if (lit_idx_q < lit_size(lit_sel_q) && c == lit_char(lit_sel_q, lit_idx_q)) begin
            lit_idx_q = lit_idx_q + 1'b1;
            if (lit_idx_q == lit_size(lit_sel_q)) begin
              if (lit_sel_q == LIT_NULL) begin
                note_token(jts_pkg::KIND_NULL, tok_start_q, jts_pkg::jts_pos_t'(4));
              end else begin
                note_token(jts_pkg::KIND_BOOL, tok_start_q,
                           jts_pkg::jts_pos_t'(lit_size(lit_sel_q)));
              end
              mode_q    = SCAN_IDLE;
              lit_idx_q = 3'd0;
            end
          end else begin
            fail_at(tok_start_q);
          end
        end
        default: begin
          mode_q = SCAN_IDLE;
          open_token(c, pos);
        end
      endcase
    end

    // The last byte flushes any pending token and closes the text.
    if (last) begin
      if (!err_q) begin
        if (mode_q == SCAN_NUMBER) begin
          note_token(jts_pkg::KIND_NUMBER, tok_start_q, nxt - tok_start_q);
        end else if (mode_q != SCAN_IDLE) begin
          fail_at(tok_start_q);
        end
      end
      note_token(jts_pkg::KIND_END, nxt, '0);
      clear_scan();
    end else begin
      pos_q = nxt;
    end

    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic void add_chars(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // Move the text under construction to the send queue, marking its last byte.
  function automatic void queue_text();
    text_byte_t it;
    foreach (text_buf[i]) begin
      it.data = text_buf[i];
      it.last = (i == text_buf.size() - 1);
      bytes_pending.push_back(it);
    end
    bytes_queued += text_buf.size();
    text_buf = {};
  endfunction

  function automatic logic [7:0] plain_string_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  function automatic void add_string_body();
    int n;
    n = $urandom_range(5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        text_buf.push_back("\\");
        text_buf.push_back(8'($urandom_range(255)));
      end else begin
        text_buf.push_back(plain_string_byte());
      end
    end
  endfunction

  function automatic void add_whitespace();
    int idx;
    idx = $urandom_range(5);
    text_buf.push_back(idx == 5 ? 8'd32 : 8'(9 + idx));
  endfunction

  // One token, well formed or deliberately broken.
  function automatic void add_random_token(bit clean);
    int pick;
    int n;
    logic [1:0] sel;
    string punct;
    string num_set;
    punct   = "{}[]:,";
    num_set = "0123456789.eE+-";
    pick = clean ? $urandom_range(7) : 8 + $urandom_range(4);
    case (pick)
      0, 1: text_buf.push_back(punct[$urandom_range(5)]);
      2, 3: begin
        text_buf.push_back("\"");
        add_string_body();
        text_buf.push_back("\"");
      end
      4, 5: begin
        if ($urandom_range(1)) text_buf.push_back("-");
        text_buf.push_back(8'(48 + $urandom_range(9)));
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) text_buf.push_back(num_set[$urandom_range(14)]);
      end
      6, 7: begin
        sel = 2'($urandom_range(2));
        for (int i = 0; i < lit_size(sel); i++) text_buf.push_back(lit_char(sel, 3'(i)));
      end
      8: text_buf.push_back(8'($urandom_range(255)));
      9: begin
        // Truncated literal followed by an arbitrary byte.
        sel = 2'($urandom_range(2));
        n = 1 + $urandom_range(lit_size(sel) - 2);
        for (int i = 0; i < n; i++) text_buf.push_back(lit_char(sel, 3'(i)));
        text_buf.push_back(8'($urandom_range(255)));
      end
      10: begin
        text_buf.push_back("-");
        text_buf.push_back(8'($urandom_range(255)));
      end
      11: begin
        text_buf.push_back("\"");
        add_string_body();
      end
      default: begin
        text_buf.push_back("\"");
        text_buf.push_back("\\");
      end
    endcase
    if ($urandom_range(99) < 60) begin
      add_whitespace();
      if ($urandom_range(3) == 0) add_whitespace();
    end
  endfunction

  // A short text; one in five carries a broken token somewhere.
  function automatic void add_random_text();
    int n;
    int bad_at;
    bit noisy;
    n      = 1 + $urandom_range(5);
    noisy  = ($urandom_range(99) < 20);
    bad_at = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) add_random_token(!(noisy && i == bad_at));
    queue_text();
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_pending.size() != 0 || in_ch.valid || tokens_due.size() != 0);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_bytes);
    int stop_at;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) add_random_text();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts tokens at each accepted request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      clear_scan();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_tokens(in_ch.data_byte, in_ch.final_byte);
        bytes_taken++;
        if (in_ch.final_byte) texts_closed++;
      end
      // Only choose a new byte once the current one has gone.
      if (!in_ch.valid || in_ch.ready) begin
        if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = bytes_pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= next_item.data;
          in_ch.final_byte <= next_item.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every accepted token is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tokens_checked++;
      kind_hits[out_ch.token_kind]++;
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d offset %0d length %0d",
               out_ch.token_kind, out_ch.token_offset, out_ch.token_length);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        if (out_ch.token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_ch.token_kind);
          errors++;
        end
        if (out_ch.token_offset !== want.offset) begin
          $error("token_offset: expected %0d, got %0d", want.offset, out_ch.token_offset);
          errors++;
        end
        if (out_ch.token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, out_ch.token_length);
          errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_ch.run_last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Timed out with %0d tokens still expected.", tokens_due.size());
    $display("json_token_scanner_test: FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'd0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    clear_scan();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts: all punctuation but ], an escaped quote with the extreme
    // byte values in a string, a number closed by a brace, a literal, a number
    // pending at the end, a bare minus, a literal mismatch, and a number ended
    // by a quote on the last byte.
    add_chars("{\"\\\"");
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    add_chars("\":-0}");
    queue_text();
    add_chars("[true,7");
    queue_text();
    add_chars("-x");
    queue_text();
    add_chars("nx");
    queue_text();
    add_chars("1\"");
    queue_text();
    wait_drained();

    // Random texts under the different idling patterns.
    run_phase(0, 0, 60);
    run_phase(74, 0, 60);
    run_phase(0, 74, 60);
    run_phase(10, 10, 60);

    // Hold the receiver off while the sender keeps pushing, so input stalls.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (bytes_pending.size() < 30) add_random_text();
    rx_hold_left = 300;
    wait_drained();

    repeat (10) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $error("%0d expected tokens never arrived", tokens_due.size());
      errors++;
    end

    kinds_seen = 0;
    for (int k = 0; k < 12; k++) if (kind_hits[k] != 0) kinds_seen++;
    $display("Scanned %0d bytes in %0d texts and checked %0d tokens.",
             bytes_taken, texts_closed, tokens_checked);
    $display("%0d of 12 token kinds seen, %0d error tokens, %0d mismatches.",
             kinds_seen, kind_hits[jts_pkg::KIND_ERROR], errors);
    if (errors == 0) begin
      $display("json_token_scanner_test: PASS");
    end else begin
      $display("json_token_scanner_test: FAIL");
    end
    $finish;
  end

endmodule
